/* hw/rtl/wprp_pkg.sv */
package wprp_pkg;

	// packet buffer
	localparam int CAP_DEPTH = 24;
	localparam int CAP_IDX_W = 5;
	localparam int RX_BUFFER_BYTES_DEF = 256;

	// length limits (bytes)
	localparam int LEN_MIN_HDR = 8;
	localparam int LEN_MIN_INIT = 13;
	localparam int LEN_MIN_INPUT = 24;

	// configuration reset
	localparam logic [15:0] BATT_FULL_MV_RST = 16'd4000;

	// packet constants
	localparam logic [7:0] MAGIC_0 = 8'h19;
	localparam logic [7:0] MAGIC_1 = 8'h81;
	localparam logic [7:0] MAGIC_2 = 8'h03;
	localparam logic [7:0] CMD_HID_A = 8'h9A;
	localparam logic [7:0] CMD_HID_B = 8'h92;
	localparam logic [7:0] CMD_INIT = 8'h94;
	localparam logic [7:0] SUBCMD_INFO = 8'h01;
	localparam logic [7:0] RPT_PLAIN = 8'h00;
	localparam logic [7:0] RPT_STD = 8'h30;

	// button ownership masks
	localparam logic [23:0] MASK_LEFT = 24'hFF2900;
	localparam logic [23:0] MASK_RIGHT = 24'h0056FF;

	// device type bits
	localparam int TYPE_LEFT_BIT = 0;
	localparam int TYPE_RIGHT_BIT = 1;

	// internal side index
	localparam logic SIDE_LEFT = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	// battery levels
	localparam logic [3:0] BATT_LOW_LEVEL = 4'd4;
	localparam logic [3:0] BATT_LIM_FULL = 4'd8;
	localparam logic [3:0] BATT_LIM_NORM = 4'd6;

	typedef enum logic [1:0] {
		KIND_IGNORED = 2'd0,
		KIND_INPUT = 2'd1,
		KIND_INIT = 2'd2,
		KIND_DETACH = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SUPPLY_NONE = 2'd0,
		SUPPLY_ON = 2'd1,
		SUPPLY_OFF = 2'd2
	} supply_t;

	// packet view handed from capture to parser
	typedef struct packed {
		logic [CAP_DEPTH-1:0][7:0] bytes;
		logic len_hdr;
		logic len_init;
		logic len_input;
	} pkt_t;

	// one result item
	typedef struct packed {
		logic valid;
		kind_t report_kind;
		logic [23:0] buttons;
		logic [11:0] left_stick_x;
		logic [11:0] left_stick_y;
		logic [11:0] right_stick_x;
		logic [11:0] right_stick_y;
		logic [3:0] left_battery;
		logic [3:0] right_battery;
		logic left_connected;
		logic right_connected;
		supply_t supply_action;
		logic [7:0] device_type;
	} res_t;

endpackage

/* hw/rtl/wprp_capture.sv */
module wprp_capture #(
	parameter int RX_BUFFER_BYTES = wprp_pkg::RX_BUFFER_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [7:0] rx_byte,
	input  logic last_byte,
	output wprp_pkg::pkt_t pkt
);

	localparam int POS_W = $clog2(RX_BUFFER_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(RX_BUFFER_BYTES);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] len;
	logic [wprp_pkg::CAP_DEPTH-1:0][7:0] cap_q;

	// saturating length including this byte
	assign len = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;

	// buffer view with the current byte merged in
	always_comb begin
		for (int i = 0; i < wprp_pkg::CAP_DEPTH; i++) begin
			pkt.bytes[i] = (en && pos_q == POS_W'(i)) ? rx_byte : cap_q[i];
		end
		pkt.len_hdr = len >= POS_W'(wprp_pkg::LEN_MIN_HDR);
		pkt.len_init = len >= POS_W'(wprp_pkg::LEN_MIN_INIT);
		pkt.len_input = len >= POS_W'(wprp_pkg::LEN_MIN_INPUT);
	end

	// byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (en) begin
			pos_q <= last_byte ? '0 : len;
		end
	end

	// packet bytes, only the head is kept
	always_ff @(posedge clk) begin
		if (en && pos_q < POS_W'(wprp_pkg::CAP_DEPTH)) begin
			cap_q[pos_q[wprp_pkg::CAP_IDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

/* hw/rtl/wprp_core.sv */
module wprp_core (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic func,
	input  logic sel,
	input  logic last_byte,
	input  logic detected,
	input  logic [15:0] system_batt_mv,
	input  logic [15:0] batt_full_mv,
	input  wprp_pkg::pkt_t pkt,
	output wprp_pkg::res_t res
);

	logic [1:0][7:0] type_q, type_n;
	logic [1:0] conn_q, conn_n;
	logic [1:0] sup_q, sup_n;
	logic [23:0] btn_q, btn_n;
	logic [11:0] lsx_q, lsy_q, rsx_q, rsy_q;
	logic [11:0] lsx_n, lsy_n, rsx_n, rsy_n;
	logic [1:0][3:0] batt_q, batt_n;

	logic magic_ok;
	logic is_input;
	logic is_init;
	logic want_on;
	logic want_off;
	logic [3:0] batt;
	logic [3:0] lim;
	logic [23:0] btn_in;
	logic [7:0] cur_type;
	wprp_pkg::kind_t kind;
	wprp_pkg::supply_t act;

	// packet classification
	assign magic_ok = pkt.len_hdr && pkt.bytes[0] == wprp_pkg::MAGIC_0
		&& pkt.bytes[1] == wprp_pkg::MAGIC_1 && pkt.bytes[2] == wprp_pkg::MAGIC_2;
	assign is_input = magic_ok && pkt.len_input
		&& (pkt.bytes[5] == wprp_pkg::CMD_HID_A || pkt.bytes[5] == wprp_pkg::CMD_HID_B)
		&& (pkt.bytes[12] == wprp_pkg::RPT_PLAIN || pkt.bytes[12] == wprp_pkg::RPT_STD);
	assign is_init = magic_ok && pkt.len_init && pkt.bytes[5] == wprp_pkg::CMD_INIT
		&& pkt.bytes[6] == wprp_pkg::SUBCMD_INFO;

	assign batt = pkt.bytes[14][7:4];
	assign btn_in = {pkt.bytes[17], pkt.bytes[16], pkt.bytes[15]};
	assign lim = (system_batt_mv > batt_full_mv) ? wprp_pkg::BATT_LIM_FULL
		: wprp_pkg::BATT_LIM_NORM;
	assign cur_type = type_q[sel];

	// next state and result
	always_comb begin
		type_n = type_q;
		conn_n = conn_q;
		sup_n = sup_q;
		btn_n = btn_q;
		lsx_n = lsx_q;
		lsy_n = lsy_q;
		rsx_n = rsx_q;
		rsy_n = rsy_q;
		batt_n = batt_q;
		kind = wprp_pkg::KIND_IGNORED;
		act = wprp_pkg::SUPPLY_NONE;
		want_on = 1'b0;
		want_off = 1'b0;
		res.valid = 1'b0;

		if (func) begin
			res.valid = !detected;
			if (!detected) begin
				kind = wprp_pkg::KIND_DETACH;
				want_off = conn_q[sel];
				conn_n[sel] = 1'b0;
				btn_n = btn_q & ~((sel == wprp_pkg::SIDE_LEFT) ? wprp_pkg::MASK_LEFT
					: wprp_pkg::MASK_RIGHT);
				batt_n[sel] = 4'd0;
			end
		end else if (last_byte) begin
			res.valid = 1'b1;
			if (is_input) begin
				kind = wprp_pkg::KIND_INPUT;
				priority if (cur_type[wprp_pkg::TYPE_LEFT_BIT]) begin
					btn_n = (btn_q & ~wprp_pkg::MASK_LEFT) | (btn_in & wprp_pkg::MASK_LEFT);
					lsx_n = {pkt.bytes[19][3:0], pkt.bytes[18]};
					lsy_n = {pkt.bytes[20], pkt.bytes[19][7:4]};
					batt_n[wprp_pkg::SIDE_LEFT] = batt;
				end else if (cur_type[wprp_pkg::TYPE_RIGHT_BIT]) begin
					btn_n = (btn_q & ~wprp_pkg::MASK_RIGHT) | (btn_in & wprp_pkg::MASK_RIGHT);
					rsx_n = {pkt.bytes[22][3:0], pkt.bytes[21]};
					rsy_n = {pkt.bytes[23], pkt.bytes[22][7:4]};
					batt_n[wprp_pkg::SIDE_RIGHT] = batt;
				end else begin
					btn_n = btn_q;
				end
				// supply decision on the charge level
				if ({batt[3:1], 1'b0} < wprp_pkg::BATT_LOW_LEVEL) begin
					want_on = 1'b1;
				end else if (batt > lim) begin
					want_off = 1'b1;
				end
			end else if (is_init) begin
				kind = wprp_pkg::KIND_INIT;
				type_n[sel] = pkt.bytes[12];
				conn_n[sel] = 1'b1;
			end
		end

		// supply request only acts on a change
		priority if (want_on && !sup_q[sel]) begin
			sup_n[sel] = 1'b1;
			act = wprp_pkg::SUPPLY_ON;
		end else if (want_off && sup_q[sel]) begin
			sup_n[sel] = 1'b0;
			act = wprp_pkg::SUPPLY_OFF;
		end else begin
			act = wprp_pkg::SUPPLY_NONE;
		end

		res.report_kind = kind;
		res.buttons = btn_n;
		res.left_stick_x = lsx_n;
		res.left_stick_y = lsy_n;
		res.right_stick_x = rsx_n;
		res.right_stick_y = rsy_n;
		res.left_battery = batt_n[wprp_pkg::SIDE_LEFT];
		res.right_battery = batt_n[wprp_pkg::SIDE_RIGHT];
		res.left_connected = conn_n[wprp_pkg::SIDE_LEFT];
		res.right_connected = conn_n[wprp_pkg::SIDE_RIGHT];
		res.supply_action = act;
		res.device_type = type_n[sel];
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= '0;
			conn_q <= '0;
			sup_q <= '0;
			btn_q <= '0;
			lsx_q <= '0;
			lsy_q <= '0;
			rsx_q <= '0;
			rsy_q <= '0;
			batt_q <= '0;
		end else if (step) begin
			type_q <= type_n;
			conn_q <= conn_n;
			sup_q <= sup_n;
			btn_q <= btn_n;
			lsx_q <= lsx_n;
			lsy_q <= lsy_n;
			rsx_q <= rsx_n;
			rsy_q <= rsy_n;
			batt_q <= batt_n;
		end
	end

endmodule

/* hw/rtl/wired_pad_report_parser_top.sv */
// channel   dir  tdata                                  tuser          tlast
// s_axis    in   rx_byte, detected, system_batt_mv      func, side     last_byte
// m_axis    out  buttons .. device_type (92 bits)       report_kind    -
// cfg       in   cfg_wdata = system_batt_full_mv, written on cfg_wen
//
// one request per cycle while m_axis keeps up: input register, then parse and state update
// into the output register, which drives m_axis
// a packet byte or attach sample yields no result, only final bytes and detach
// samples do; a stalled output holds the parse stage and so s_axis_tready
// arst_n clears byte count and controller state and sets the threshold to 4000 mV
module wired_pad_report_parser_top #(
	parameter int RX_BUFFER_BYTES = wprp_pkg::RX_BUFFER_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// rx_byte[7:0], detected[8], system_batt_mv[24:9], zero pad
	input  logic [31:0] s_axis_tdata,
	// func[0], side[1]
	input  logic [1:0] s_axis_tuser,
	input  logic s_axis_tlast,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// buttons[23:0], left_stick_x[35:24], left_stick_y[47:36],
	// right_stick_x[59:48], right_stick_y[71:60], left_battery[75:72],
	// right_battery[79:76], left_connected[80], right_connected[81],
	// supply_action[83:82], device_type[91:84], zero pad
	output logic [95:0] m_axis_tdata,
	// report_kind[1:0]
	output logic [1:0] m_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic cfg_wen,
	input  logic [15:0] cfg_wdata
);

	logic valid_s1;
	logic func_s1;
	logic side_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic det_s1;
	logic [15:0] sys_mv_s1;
	logic [15:0] full_mv_q;
	logic out_valid_q;
	wprp_pkg::res_t out_q;
	wprp_pkg::res_t res;
	wprp_pkg::pkt_t pkt;
	logic adv;
	logic step;
	logic sel;

	// parse stage moves unless its result has nowhere to go
	assign adv = !res.valid || !out_valid_q || m_axis_tready;
	assign step = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;
	assign sel = ~side_s1;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_mv_q <= wprp_pkg::BATT_FULL_MV_RST;
		end else if (cfg_wen) begin
			full_mv_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			func_s1 <= s_axis_tuser[0];
			side_s1 <= s_axis_tuser[1];
			byte_s1 <= s_axis_tdata[7:0];
			det_s1 <= s_axis_tdata[8];
			sys_mv_s1 <= s_axis_tdata[24:9];
			last_s1 <= s_axis_tlast;
		end
	end

	wprp_capture #(
		.RX_BUFFER_BYTES(RX_BUFFER_BYTES)
	) u_capture (
		.clk(clk),
		.arst_n(arst_n),
		.en(step && !func_s1),
		.rx_byte(byte_s1),
		.last_byte(last_s1),
		.pkt(pkt)
	);

	wprp_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.func(func_s1),
		.sel(sel),
		.last_byte(last_s1),
		.detected(det_s1),
		.system_batt_mv(sys_mv_s1),
		.batt_full_mv(full_mv_q),
		.pkt(pkt),
		.res(res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_q.report_kind;
	assign m_axis_tdata = {4'd0, out_q.device_type, out_q.supply_action,
		out_q.right_connected, out_q.left_connected, out_q.right_battery,
		out_q.left_battery, out_q.right_stick_y, out_q.right_stick_x,
		out_q.left_stick_y, out_q.left_stick_x, out_q.buttons};

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !(step && res.valid))
		else $error("result register overwritten while stalled");

	// a held parse stage keeps its request
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1) && $stable(func_s1))
		else $error("parse stage lost a held request");

	// a detach leaves its side disconnected
	assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.report_kind == wprp_pkg::KIND_DETACH
		|-> (side_s1 ? !res.left_connected : !res.right_connected))
		else $error("detach left side connected");

endmodule
